[rtl/tlbs_pkg.sv]
// Shared types, codes and constant tables for the activity LED blink selector.
package tlbs_pkg;

  localparam int ROW_COUNT = 10;
  localparam logic [3:0] SOLID_ROW = 4'd10;
  localparam logic [7:0] SOLID_ON_TIME = 8'd11;
  localparam int MBIT_SHIFT = 17;

  localparam logic [15:0] RATE_MBPS [ROW_COUNT] = '{
    16'd300, 16'd200, 16'd100, 16'd70, 16'd50, 16'd20, 16'd10, 16'd5, 16'd1, 16'd0
  };
  localparam logic [7:0] ROW_TIME [ROW_COUNT] = '{
    8'd25, 8'd40, 8'd55, 8'd65, 8'd75, 8'd85, 8'd95, 8'd110, 8'd130, 8'd167
  };

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_BLINK_MODE = 2'd0;
  localparam logic [1:0] REG_TIME_COMP = 2'd1;
  localparam logic [1:0] REG_UPDATE_INTERVAL = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ASSOC    = 2'd1,
    ACT_DISASSOC = 2'd2,
    ACT_INIT     = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] now_time;
    logic [63:0] traffic_bytes;
    logic        exit_pending;
    logic        rf_killed;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pattern_index;
    logic [7:0] on_time;
    logic [7:0] dark_time;
  } out_item_t;

  typedef struct packed {
    logic        blink_mode;
    logic [15:0] time_compensation;
    logic [15:0] update_interval;
  } cfg_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } eval_t;

endpackage

[rtl/tlbs_cfg.sv]
// APB-style configuration register file.
module tlbs_cfg
  import tlbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_mode        <= 1'b0;
      cfg_r.time_compensation <= 16'd64;
      cfg_r.update_interval   <= 16'd1000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLINK_MODE:      cfg_r.blink_mode        <= pwdata[0];
        REG_TIME_COMP:       cfg_r.time_compensation <= pwdata[15:0];
        REG_UPDATE_INTERVAL: cfg_r.update_interval   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLINK_MODE:      prdata = {31'd0, cfg_r.blink_mode};
      REG_TIME_COMP:       prdata = {16'd0, cfg_r.time_compensation};
      REG_UPDATE_INTERVAL: prdata = {16'd0, cfg_r.update_interval};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

[rtl/tlbs_eval.sv]
// Event evaluation: blink state registers, throughput row select and time scaling.
module tlbs_eval
  import tlbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  input  cfg_t     cfg,
  output eval_t    ev
);

  logic [63:0] prev_traffic_r, prev_traffic_nxt;
  logic [3:0]  cur_index_r, cur_index_nxt;
  logic        allowed_r, allowed_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        armed_r, armed_nxt;

  logic [31:0] diff;
  logic [63:0] raw_delta;
  logic [63:0] delta;
  logic [3:0]  sel_idx;
  logic [3:0]  res_idx;
  logic        emit;
  logic [7:0]  base_on;
  logic [7:0]  base_off;
  logic [23:0] on_prod;
  logic [23:0] off_prod;

  assign diff      = item.now_time - (last_time_r + {16'd0, cfg.update_interval});
  assign raw_delta = item.traffic_bytes - prev_traffic_r;
  assign delta     = raw_delta[63] ? (64'd0 - raw_delta) : raw_delta;

  always_comb begin
    sel_idx = SOLID_ROW;
    for (int i = ROW_COUNT - 1; i >= 0; i--) begin
      if (delta > (64'(RATE_MBPS[i]) << MBIT_SHIFT)) begin
        sel_idx = 4'(i);
      end
    end
  end

  always_comb begin
    prev_traffic_nxt = prev_traffic_r;
    cur_index_nxt    = cur_index_r;
    allowed_nxt      = allowed_r;
    last_time_nxt    = last_time_r;
    armed_nxt        = armed_r;
    emit             = 1'b0;
    res_idx          = SOLID_ROW;
    case (item.action)
      ACT_ASSOC: begin
        if (!cfg.blink_mode) begin
          allowed_nxt = 1'b1;
        end
        last_time_nxt = item.now_time;
        armed_nxt     = 1'b1;
      end
      ACT_DISASSOC: begin
        allowed_nxt = 1'b0;
      end
      ACT_INIT: begin
        cur_index_nxt = 4'd0;
        last_time_nxt = 32'd0;
        armed_nxt     = 1'b0;
        allowed_nxt   = 1'b0;
      end
      default: begin
        if (item.exit_pending || item.rf_killed) begin
          last_time_nxt = 32'd0;
          armed_nxt     = 1'b0;
        end else if (!allowed_r) begin
          last_time_nxt = 32'd0;
          armed_nxt     = 1'b0;
          if (cur_index_r != SOLID_ROW) begin
            cur_index_nxt = SOLID_ROW;
            emit          = 1'b1;
          end
        end else if (armed_r && diff != 32'd0 && !diff[31]) begin
          prev_traffic_nxt = item.traffic_bytes;
          res_idx          = sel_idx;
          emit             = (sel_idx != cur_index_r);
          last_time_nxt    = item.now_time;
          armed_nxt        = 1'b1;
          cur_index_nxt    = sel_idx;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_traffic_r <= 64'd0;
      cur_index_r    <= 4'd0;
      allowed_r      <= 1'b0;
      last_time_r    <= 32'd0;
      armed_r        <= 1'b0;
    end else if (step) begin
      prev_traffic_r <= prev_traffic_nxt;
      cur_index_r    <= cur_index_nxt;
      allowed_r      <= allowed_nxt;
      last_time_r    <= last_time_nxt;
      armed_r        <= armed_nxt;
    end
  end

  always_comb begin
    if (res_idx < 4'(ROW_COUNT)) begin
      base_on  = ROW_TIME[res_idx];
      base_off = ROW_TIME[res_idx];
    end else begin
      base_on  = SOLID_ON_TIME;
      base_off = 8'd0;
    end
  end

  assign on_prod  = {16'd0, base_on} * {8'd0, cfg.time_compensation};
  assign off_prod = {16'd0, base_off} * {8'd0, cfg.time_compensation};

  always_comb begin
    ev.emit               = emit;
    ev.item.pattern_index = res_idx;
    if (cfg.time_compensation == 16'd0) begin
      ev.item.on_time   = base_on;
      ev.item.dark_time = base_off;
    end else begin
      ev.item.on_time   = on_prod[13:6];
      ev.item.dark_time = off_prod[13:6];
    end
  end

endmodule

[rtl/throughput_led_blink_selector.sv]
// Top level of the activity LED blink selector: input register, evaluation, result register.
//
// One event transaction is taken per clock cycle while the input register can advance. An
// accepted event sits in the input register while the evaluation logic updates the blink
// state and, when the chosen pattern changes, loads the result register; a command thus
// passes from the input register through the result register to the output. The event
// only waits when it produces a command and out_ready low still holds the result register,
// so the rate is one event per cycle otherwise. Configuration is to be written by the user
// through the APB-style port only while no event is in flight; the block does not enforce it.
module throughput_led_blink_selector
  import tlbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  eval_t     ev;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      s1_advance;
  logic      in_fire;

  tlbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlbs_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_advance),
    .item  (s1_item_r),
    .cfg   (cfg),
    .ev    (ev)
  );

  assign s1_advance = s1_valid_r && (!ev.emit || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_advance && ev.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_advance && ev.emit) begin
      out_item_r <= ev.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

[sim/led_pattern_checker.sv]
// Checker for the activity LED blink selector: tracks events and config, compares pattern commands.
`timescale 1ns / 100ps
module led_pattern_checker
  import tlbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 fails,
  output int                 pending
);

  localparam logic [3:0] LED_SOLID = 4'd10;
  localparam logic [7:0] LED_SOLID_TIME = 8'd11;
  localparam int RATE_SHIFT = 17;
  localparam logic [8:0] LINE_RATE [10] = '{
    9'd300, 9'd200, 9'd100, 9'd70, 9'd50, 9'd20, 9'd10, 9'd5, 9'd1, 9'd0
  };
  localparam logic [7:0] LINE_TIME [10] = '{
    8'd25, 8'd40, 8'd55, 8'd65, 8'd75, 8'd85, 8'd95, 8'd110, 8'd130, 8'd167
  };

  logic        mode_solid;
  logic [15:0] comp;
  logic [15:0] upd_ivl;
  logic [63:0] prev_bytes;
  logic [3:0]  cur_row;
  logic        blink_ok;
  logic [31:0] last_upd;
  logic        armed;

  out_item_t pending_patterns [$];

  function automatic logic [7:0] scaled(input logic [7:0] t);
    logic [23:0] prod;
    if (comp == 16'd0) return t;
    prod = 24'(t) * 24'(comp);
    return prod[13:6];
  endfunction

  function automatic out_item_t pattern_for(input logic [3:0] row);
    out_item_t p;
    p.pattern_index = row;
    if (row == LED_SOLID) begin
      p.on_time = scaled(LED_SOLID_TIME);
      p.dark_time = scaled(8'd0);
    end else begin
      p.on_time = scaled(LINE_TIME[row]);
      p.dark_time = scaled(LINE_TIME[row]);
    end
    return p;
  endfunction

  function automatic void advance_blink_state(input in_item_t ev);
    logic [31:0] lag;
    logic [63:0] delta;
    logic [3:0] row;
    case (ev.action)
      ACT_ASSOC: begin
        if (!mode_solid) blink_ok = 1'b1;
        last_upd = ev.now_time;
        armed = 1'b1;
      end
      ACT_DISASSOC: blink_ok = 1'b0;
      ACT_INIT: begin
        cur_row = 4'd0;
        last_upd = '0;
        armed = 1'b0;
        blink_ok = 1'b0;
      end
      default: begin
        if (ev.exit_pending || ev.rf_killed) begin
          last_upd = '0;
          armed = 1'b0;
        end else if (!blink_ok) begin
          last_upd = '0;
          armed = 1'b0;
          if (cur_row != LED_SOLID) begin
            cur_row = LED_SOLID;
            pending_patterns.push_back(pattern_for(LED_SOLID));
          end
        end else if (armed) begin
          lag = ev.now_time - (last_upd + 32'(upd_ivl));
          if (lag != 32'd0 && !lag[31]) begin
            delta = ev.traffic_bytes - prev_bytes;
            if (delta[63]) delta = 64'd0 - delta;
            prev_bytes = ev.traffic_bytes;
            row = LED_SOLID;
            for (int i = 9; i >= 0; i--)
              if (delta > (64'(LINE_RATE[i]) << RATE_SHIFT)) row = 4'(i);
            if (row != cur_row) pending_patterns.push_back(pattern_for(row));
            last_upd = ev.now_time;
            armed = 1'b1;
            cur_row = row;
          end
        end
      end
    endcase
  endfunction

  function automatic void report(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_BLINK_MODE:      return {31'd0, mode_solid};
      REG_TIME_COMP:       return {16'd0, comp};
      REG_UPDATE_INTERVAL: return {16'd0, upd_ivl};
      default:             return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t exp_p;
    logic [1:0] idx;
    if (!rst_n) begin
      comp = 16'd64;
      upd_ivl = 16'd1000;
      mode_solid = 1'b0;
      prev_bytes = '0;
      cur_row = '0;
      blink_ok = 1'b0;
      last_upd = '0;
      armed = 1'b0;
      pending_patterns.delete();
      fails = 0;
    end else begin
      if (psel && penable && pready) begin
        idx = paddr[PADDR_W-1:2];
        if (pwrite) begin
          case (idx)
            REG_BLINK_MODE:      mode_solid = pwdata[0];
            REG_TIME_COMP:       comp = pwdata[15:0];
            REG_UPDATE_INTERVAL: upd_ivl = pwdata[15:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(idx)) begin
          report($sformatf("register %0d read exp %h got %h", idx, reg_value(idx), prdata));
        end
      end
      if (out_valid && out_ready) begin
        if (pending_patterns.size() == 0) begin
          report($sformatf("unexpected transaction idx=%0d on=%0d off=%0d",
                           out_data.pattern_index, out_data.on_time, out_data.dark_time));
        end else begin
          exp_p = pending_patterns.pop_front();
          if (out_data.pattern_index !== exp_p.pattern_index ||
              out_data.on_time !== exp_p.on_time ||
              out_data.dark_time !== exp_p.dark_time)
            report($sformatf("exp idx=%0d on=%0d off=%0d got idx=%0d on=%0d off=%0d",
                             exp_p.pattern_index, exp_p.on_time, exp_p.dark_time,
                             out_data.pattern_index, out_data.on_time, out_data.dark_time));
        end
      end
      if (in_valid && in_ready) advance_blink_state(in_data);
    end
    pending = pending_patterns.size();
  end

endmodule

[sim/tb.sv]
// Testbench top for the activity LED blink selector: stimulus, idling and final verdict.
`timescale 1ns / 100ps
module tb;
  import tlbs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fails;
  int pending;
  int cycles = 0;
  int out_wait = 0;
  bit out_took = 1'b0;
  bit quiet = 1'b0;

  logic [31:0] t_now;
  logic [63:0] t_bytes;
  int          ivl;

  throughput_led_blink_selector u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  led_pattern_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    out_took = rst_n && out_valid && out_ready;

  always @(negedge clk) begin
    if (out_took) out_wait = quiet ? 0 : $urandom_range(0, 5);
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_read(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic mode, input logic [15:0] comp,
                              input logic [15:0] upd);
    apb_write(REG_BLINK_MODE, {31'd0, mode});
    apb_write(REG_TIME_COMP, {16'd0, comp});
    apb_write(REG_UPDATE_INTERVAL, {16'd0, upd});
    apb_read(REG_BLINK_MODE);
    apb_read(REG_TIME_COMP);
    apb_read(REG_UPDATE_INTERVAL);
    ivl = upd;
  endtask

  task automatic send(input action_t act, input logic [31:0] now, input logic [63:0] bytes,
                      input logic ex, input logic kill);
    in_item_t it;
    int gap;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    gap = quiet ? 0 : $urandom_range(0, 5);
    it.action = act;
    it.now_time = now;
    it.traffic_bytes = bytes;
    it.exit_pending = ex;
    it.rf_killed = kill;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_events(input int n);
    logic [63:0] d;
    int row;
    int pick;
    logic [31:0] adv;
    send(ACT_ASSOC, t_now, t_bytes, 1'b0, 1'b0);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        t_now += $urandom_range(0, 20);
        send(ACT_ASSOC, t_now, t_bytes, 1'b0, 1'b0);
      end else if (pick < 9) begin
        send(ACT_DISASSOC, $urandom, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
      end else if (pick < 11) begin
        send(ACT_INIT, $urandom, {$urandom, $urandom}, 1'($urandom), 1'($urandom));
      end else if (pick < 14) begin
        send(action_t'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
             1'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0: adv = $urandom_range(0, ivl);
          1: adv = ivl;
          default: adv = ivl + $urandom_range(1, 50);
        endcase
        t_now += adv;
        row = $urandom_range(0, 10);
        if (row == 10) begin
          d = '0;
        end else begin
          d = 64'(RATE_MBPS[row]) << MBIT_SHIFT;
          case ($urandom_range(0, 3))
            1: d += 1;
            2: if (d != 0) d -= 1;
            3: d += $urandom_range(0, 1 << 17);
            default: ;
          endcase
        end
        if ($urandom_range(0, 49) == 0) d = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) t_bytes -= d;
        else t_bytes += d;
        send(ACT_TICK, t_now, t_bytes, 1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    logic [63:0] b;
    logic        p_mode [6];
    logic [15:0] p_comp [6];
    logic [15:0] p_ivl [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    p_mode = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    p_comp = '{16'd0, 16'd65535, 16'd100, 16'd1, 16'($urandom), 16'd64};
    p_ivl = '{16'd1, 16'd65535, 16'd50, 16'd7, 16'($urandom_range(1, 65535)), 16'd1000};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_regs(1'b0, 16'd64, 16'd1000);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    apb_read(REG_TIME_COMP);

    // directed: solid after reset, flags, timing edges, row thresholds, wrap, init
    send(ACT_TICK, 32'd0, 64'd0, 1'b0, 1'b0);
    send(ACT_TICK, 32'd5, 64'd0, 1'b0, 1'b0);
    send(ACT_TICK, 32'd0, 64'd0, 1'b1, 1'b0);
    send(ACT_TICK, 32'd0, 64'd0, 1'b0, 1'b1);
    send(ACT_ASSOC, 32'd0, 64'd0, 1'b0, 1'b0);
    send(ACT_TICK, 32'd1000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send(ACT_TICK, 32'd999, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    b = (64'd300 << 17) + 64'd1;
    send(ACT_TICK, 32'd1001, b, 1'b0, 1'b0);
    send(ACT_TICK, 32'd2002, b, 1'b0, 1'b0);
    b = b - ((64'd1 << 17) + 64'd1);
    send(ACT_TICK, 32'd3003, b, 1'b0, 1'b0);
    b = b + (64'd1 << 17);
    send(ACT_TICK, 32'd4004, b, 1'b0, 1'b0);
    b = b + (64'd300 << 17);
    send(ACT_TICK, 32'd5005, b, 1'b0, 1'b0);
    send(ACT_DISASSOC, 32'd5500, b, 1'b0, 1'b0);
    send(ACT_TICK, 32'd6006, b, 1'b0, 1'b0);
    send(ACT_ASSOC, 32'hFFFF_FF00, b, 1'b0, 1'b0);
    send(ACT_TICK, 32'h0000_02F0, b + 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    send(ACT_TICK, 32'h0000_0700, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send(ACT_TICK, 32'h0000_0B00, 64'd0, 1'b1, 1'b1);
    send(ACT_TICK, 32'h0000_1000, 64'd12345, 1'b0, 1'b0);
    send(ACT_INIT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send(ACT_TICK, 32'h0000_2000, 64'd0, 1'b0, 1'b0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      program_regs(p_mode[ph], p_comp[ph], p_ivl[ph]);
      t_now = (ph == 5) ? 32'hFFFF_F000 : $urandom;
      t_bytes = {$urandom, $urandom};
      random_events(240);
      settle();
    end

    if (fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/tlbs_pkg.sv
rtl/tlbs_cfg.sv
rtl/tlbs_eval.sv
rtl/throughput_led_blink_selector.sv
sim/led_pattern_checker.sv
sim/tb.sv
